[sv/mpe_pkg.sv]
// Shared constants, types and codes for the feedback priority engine.
// No dependencies; every other file of the block imports this package.
package mpe_pkg;

	localparam int MAX_THREADS_DEF      = 16;
	localparam int TICKS_PER_SECOND_DEF = 100;
	localparam int TOP_PRIORITY         = 63;
	localparam int FRAC_BITS            = 14;
	localparam int FONE                 = 1 << FRAC_BITS;

	localparam int REC_W  = 32;
	localparam int LA_W   = 31;
	localparam int NICE_W = 6;
	localparam int PRIO_W = 6;
	localparam int COEF_W = FRAC_BITS + 1;
	localparam int RDY_W  = 10;

	localparam int C5960      = (59 * FONE) / 60;
	localparam int READY_DIV  = 60;
	localparam int X100       = 100;
	localparam int REC_X_MAX  = 100000000;
	localparam int LA_X_MAX   = 2047;
	localparam int NICE_LIMIT = 20;

	localparam int DIV_NUM_W = LA_W + FRAC_BITS + 2;
	localparam int DIV_DEN_W = LA_W + 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_NICE   = 3'd1,
		CMD_CREATE = 3'd2,
		CMD_EXIT   = 3'd3,
		CMD_SWITCH = 3'd4,
		CMD_QUERY  = 3'd5
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE = 2'd0,
		CFG_SLICE  = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [REC_W-1:0]  recent;
		logic signed [NICE_W-1:0] nice;
		logic [PRIO_W-1:0]        prio;
	} mpe_entry_t;

endpackage

[sv/mpe_if.sv]
// Handshake channels of the priority engine: request, response, register write.
// Depends on mpe_pkg for field widths.
interface mpe_req_if import mpe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [2:0]               cmd;
	logic [3:0]               slot;
	logic                     running_idle;
	logic [3:0]               parent_slot;
	logic signed [NICE_W-1:0] nice_value;
	logic [PRIO_W-1:0]        initial_priority;
	logic [4:0]               ready_count;

	modport source (output valid, cmd, slot, running_idle, parent_slot, nice_value,
		initial_priority, ready_count, input ready);
	modport sink (input valid, cmd, slot, running_idle, parent_slot, nice_value,
		initial_priority, ready_count, output ready);
endinterface

interface mpe_rsp_if import mpe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     yield_request;
	logic [PRIO_W-1:0]        priority_out;
	logic signed [NICE_W-1:0] nice_out;
	logic signed [27:0]       recent_cpu_x100;
	logic [10:0]              load_avg_x100;
	logic                     status;

	modport source (output valid, yield_request, priority_out, nice_out, recent_cpu_x100,
		load_avg_x100, status, input ready);
	modport sink (input valid, yield_request, priority_out, nice_out, recent_cpu_x100,
		load_avg_x100, status, output ready);
endinterface

interface mpe_cfg_if import mpe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/mpe_table_mem.sv]
// Thread table: one synchronous memory, one write and one registered read port.
// Depends on mpe_pkg for the entry type.
module mpe_table_mem import mpe_pkg::*; #(
	parameter int DEPTH = MAX_THREADS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic       clk,
	input  logic       we,
	input  logic [AW-1:0] waddr,
	input  mpe_entry_t wdata,
	input  logic [AW-1:0] raddr,
	output mpe_entry_t rdata
);

	mpe_entry_t mem [DEPTH];
	mpe_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/mpe_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mpe_pkg for operand widths.
module mpe_div import mpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 busy,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);

	localparam int CW = $clog2(DIV_NUM_W + 1);

	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_diff;
	logic                 take;

	assign rem_sh   = {rem_q, quo_q[DIV_NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign take     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

[sv/mlfqs_priority_engine.sv]
// Feedback priority engine: thread table in one memory, iterative divider, control FSM.
// The next request can be accepted in the cycle after the response is loaded. When enabled,
// the once-a-second tick also updates the load average, divides for the decay coefficient
// and walks every thread's recent CPU, and slice expiry walks every thread's priority.
// Reset clears valid bits, load average and counters; it sets config to enabled, slice 4.
// Depends on mpe_pkg, mpe_if, mpe_table_mem, mpe_div.
module mlfqs_priority_engine import mpe_pkg::*; #(
	parameter int MAX_THREADS      = MAX_THREADS_DEF,
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mpe_req_if.sink   req,
	mpe_rsp_if.source rsp,
	mpe_cfg_if.sink   cfg
);

	localparam int IW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int SCW   = $clog2(TICKS_PER_SECOND + 1);
	localparam int PROD_W = LA_W + FRAC_BITS;
	localparam int RCP_W = REC_W + COEF_W + 1;
	localparam int RX_W  = REC_W + 8;
	localparam int LX_W  = LA_W + 7;
	localparam int PV_W  = 20;
	localparam int RT_N  = MAX_THREADS + 2;
	localparam int RT_AW = $clog2(RT_N);
	localparam logic signed [RX_W-1:0] X100_S = RX_W'(X100);
	localparam logic signed [NICE_W-1:0] NICE_HI = NICE_W'(NICE_LIMIT);
	localparam logic signed [NICE_W-1:0] NICE_LO = NICE_W'(-NICE_LIMIT);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_CHG_RD, S_CHG_WR, S_SEC, S_LA_MUL, S_LA_SUM, S_DIV2,
		S_RC_RD, S_RC_MUL, S_RC_WR, S_SLICE, S_PR_RD, S_PR_WR, S_ENT_RD, S_ENT_WR,
		S_OUT_RD, S_OUT_MUL, S_OUT_FIN
	} state_t;

	state_t state_q;

	cmd_t                     cmd_q;
	logic [3:0]               slot_q;
	logic                     idle_q;
	logic [3:0]               parent_q;
	logic signed [NICE_W-1:0] nice_q;
	logic [PRIO_W-1:0]        ipri_q;
	logic [4:0]               ready_q;

	logic                     enable_q;
	logic [3:0]               tslice_q;
	logic [MAX_THREADS-1:0]   valid_q;
	logic [LA_W-1:0]          load_avg_q;
	logic [SCW-1:0]           sec_q;
	logic [3:0]               slice_q;
	logic [IW-1:0]            walk_q;
	logic [PROD_W-1:0]        prod_q;
	logic [LA_W-1:0]          la_add_q;
	logic [COEF_W-1:0]        coef_q;
	logic signed [RCP_W-1:0]  rc_s2;
	logic signed [RX_W-1:0]   rx_s2;
	logic [LX_W-1:0]          lx_s2;
	logic                     live_s2;
	logic [PRIO_W-1:0]        pri_s2;
	logic signed [NICE_W-1:0] nice_s2;
	logic                     yield_q;
	logic                     status_q;

	logic                     out_valid_q;
	logic                     out_yield_q;
	logic [PRIO_W-1:0]        out_pri_q;
	logic signed [NICE_W-1:0] out_nice_q;
	logic signed [27:0]       out_rec_q;
	logic [10:0]              out_la_q;
	logic                     out_status_q;
	logic                     out_load;

	logic [IW-1:0]   slot_a;
	logic [IW-1:0]   par_a;
	logic            slot_in;
	logic            live_slot;
	logic            par_live;
	logic signed [NICE_W-1:0] nice_clamp;

	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_raddr;
	mpe_entry_t      mem_wdata;
	mpe_entry_t      rd;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_busy;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;

	logic [RDY_W-1:0]     rdy_tot;
	logic [LA_W-1:0]      la_add_tab [RT_N];
	logic [LA_W:0]        la_sum;
	logic [LA_W-1:0]      la_next;
	logic [SCW-1:0]       sec_inc;
	logic [3:0]           slice_next;
	logic [REC_W:0]       chg_sum;
	logic [REC_W-1:0]     chg_sat;
	logic signed [RCP_W-1:0] rc_t;
	logic signed [RCP_W-1:0] rc_sum;
	logic [REC_W-1:0]     rc_sat;

	logic                 rx_neg;
	logic [RX_W-1:0]      rx_mag;
	logic [RX_W-1:0]      rx_rnd;
	logic [26:0]          rx_cl;
	logic [LX_W-1:0]      lx_rnd;

	function automatic logic [PRIO_W-1:0] calc_prio(input logic signed [REC_W-1:0] rec,
		input logic signed [NICE_W-1:0] nv);
		logic signed [REC_W:0]  adj;
		logic signed [REC_W:0]  q;
		logic signed [PV_W-1:0] pv;
		adj = (REC_W+1)'(rec) + (rec[REC_W-1] ? (REC_W+1)'(4 * FONE - 1) : '0);
		q   = adj >>> (FRAC_BITS + 2);
		pv  = PV_W'(TOP_PRIORITY) - PV_W'(q) - (PV_W'(nv) <<< 1);
		if (pv < 0) begin
			return '0;
		end else if (pv > PV_W'(TOP_PRIORITY)) begin
			return PRIO_W'(TOP_PRIORITY);
		end
		return pv[PRIO_W-1:0];
	endfunction

	// ready*F/60 for every possible ready total
	for (genvar g = 0; g < RT_N; g++) begin : g_la_add
		assign la_add_tab[g] = LA_W'((g * FONE) / READY_DIV);
	end

	assign slot_a    = IW'(slot_q);
	assign par_a     = IW'(parent_q);
	assign slot_in   = int'(slot_q) < MAX_THREADS;
	assign live_slot = slot_in && valid_q[slot_a];
	assign par_live  = (int'(parent_q) < MAX_THREADS) && valid_q[par_a];

	assign nice_clamp = (req.nice_value > NICE_HI) ? NICE_HI :
		(req.nice_value < NICE_LO) ? NICE_LO : req.nice_value;

	assign rdy_tot = ((int'(ready_q) > MAX_THREADS) ? RDY_W'(MAX_THREADS) : RDY_W'(ready_q))
		+ RDY_W'(!idle_q);
	assign la_sum  = (LA_W+1)'(prod_q >> FRAC_BITS) + (LA_W+1)'(la_add_q);
	assign la_next = la_sum[LA_W] ? {LA_W{1'b1}} : la_sum[LA_W-1:0];
	assign sec_inc = sec_q + SCW'(1);
	assign slice_next = (slice_q != 4'hf) ? slice_q + 4'd1 : slice_q;

	assign chg_sum = (REC_W+1)'(rd.recent) + (REC_W+1)'(FONE);
	assign chg_sat = (chg_sum[REC_W] != chg_sum[REC_W-1]) ? {1'b0, {(REC_W-1){1'b1}}}
		: chg_sum[REC_W-1:0];

	assign rc_t   = (rc_s2 + (rc_s2[RCP_W-1] ? RCP_W'(FONE - 1) : '0)) >>> FRAC_BITS;
	assign rc_sum = rc_t + (RCP_W'(rd.nice) <<< FRAC_BITS);
	assign rc_sat = (rc_sum[RCP_W-1:REC_W-1] != {(RCP_W-REC_W+1){rc_sum[RCP_W-1]}}) ?
		(rc_sum[RCP_W-1] ? {1'b1, {(REC_W-1){1'b0}}} : {1'b0, {(REC_W-1){1'b1}}})
		: rc_sum[REC_W-1:0];

	assign rx_neg = rx_s2[RX_W-1];
	assign rx_mag = rx_neg ? RX_W'(-rx_s2) : RX_W'(rx_s2);
	assign rx_rnd = (rx_mag + RX_W'(FONE / 2)) >> FRAC_BITS;
	assign rx_cl  = (rx_rnd > RX_W'(REC_X_MAX)) ? 27'(REC_X_MAX) : rx_rnd[26:0];
	assign lx_rnd = (lx_s2 + LX_W'(FONE / 2)) >> FRAC_BITS;

	assign div_start = (state_q == S_LA_SUM);
	assign div_num   = DIV_NUM_W'(la_next) << (FRAC_BITS + 1);
	assign div_den   = DIV_DEN_W'({la_next, 1'b0}) + DIV_DEN_W'(FONE);

	assign out_load = (state_q == S_OUT_FIN) && (!out_valid_q || rsp.ready);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_a;
		mem_raddr = slot_a;
		mem_wdata = rd;
		unique case (state_q)
			S_CHG_WR: begin
				mem_we           = 1'b1;
				mem_wdata.recent = chg_sat;
			end
			S_RC_RD, S_RC_MUL, S_PR_RD: begin
				mem_raddr = walk_q;
			end
			S_RC_WR: begin
				mem_raddr        = walk_q;
				mem_waddr        = walk_q;
				mem_we           = valid_q[walk_q];
				mem_wdata.recent = rc_sat;
			end
			S_PR_WR: begin
				mem_raddr      = walk_q;
				mem_waddr      = walk_q;
				mem_we         = valid_q[walk_q];
				mem_wdata.prio = calc_prio(rd.recent, rd.nice);
			end
			S_ENT_RD: begin
				mem_raddr = (cmd_q == CMD_CREATE) ? par_a : slot_a;
			end
			S_ENT_WR: begin
				mem_we = 1'b1;
				if (cmd_q == CMD_NICE) begin
					mem_wdata.nice = nice_q;
					if (enable_q) begin
						mem_wdata.prio = calc_prio(rd.recent, nice_q);
					end
				end else if (cmd_q == CMD_CREATE) begin
					mem_wdata.recent = par_live ? rd.recent : '0;
					mem_wdata.nice   = par_live ? rd.nice : '0;
					mem_wdata.prio   = (int'(ipri_q) > TOP_PRIORITY) ?
						PRIO_W'(TOP_PRIORITY) : ipri_q;
				end else begin
					mem_wdata = '0;
				end
			end
			default: begin
			end
		endcase
	end

	mpe_table_mem #(.DEPTH(MAX_THREADS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	mpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			tslice_q <= 4'd4;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ENABLE: enable_q <= cfg.data[0];
				CFG_SLICE:  tslice_q <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			load_avg_q  <= '0;
			sec_q       <= '0;
			slice_q     <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
			yield_q     <= 1'b0;
			status_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					yield_q  <= 1'b0;
					status_q <= 1'b0;
					unique case (cmd_q)
						CMD_TICK: begin
							status_q <= !idle_q && !live_slot;
							state_q  <= (enable_q && !idle_q && live_slot) ? S_CHG_RD : S_SEC;
						end
						CMD_NICE, CMD_EXIT: begin
							status_q <= !live_slot;
							state_q  <= !live_slot ? S_OUT_RD :
								(cmd_q == CMD_NICE) ? S_ENT_RD : S_ENT_WR;
						end
						CMD_CREATE: begin
							state_q <= !slot_in ? S_OUT_RD : par_live ? S_ENT_RD : S_ENT_WR;
						end
						CMD_SWITCH: begin
							slice_q <= '0;
							state_q <= S_OUT_RD;
						end
						default: begin
							status_q <= !live_slot;
							state_q  <= S_OUT_RD;
						end
					endcase
				end
				S_CHG_RD: state_q <= S_CHG_WR;
				S_CHG_WR: state_q <= S_SEC;
				S_SEC: begin
					if (int'(sec_inc) >= TICKS_PER_SECOND) begin
						sec_q   <= '0;
						state_q <= enable_q ? S_LA_MUL : S_SLICE;
					end else begin
						sec_q   <= sec_inc;
						state_q <= S_SLICE;
					end
				end
				S_LA_MUL: state_q <= S_LA_SUM;
				S_LA_SUM: begin
					load_avg_q <= la_next;
					state_q    <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						walk_q  <= '0;
						state_q <= S_RC_RD;
					end
				end
				S_RC_RD:  state_q <= S_RC_MUL;
				S_RC_MUL: state_q <= S_RC_WR;
				S_RC_WR: begin
					if (walk_q == IW'(MAX_THREADS - 1)) begin
						state_q <= S_SLICE;
					end else begin
						walk_q  <= walk_q + IW'(1);
						state_q <= S_RC_RD;
					end
				end
				S_SLICE: begin
					slice_q <= slice_next;
					if (slice_next >= tslice_q) begin
						yield_q <= 1'b1;
						walk_q  <= '0;
						state_q <= enable_q ? S_PR_RD : S_OUT_RD;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				S_PR_RD: state_q <= S_PR_WR;
				S_PR_WR: begin
					if (walk_q == IW'(MAX_THREADS - 1)) begin
						state_q <= S_OUT_RD;
					end else begin
						walk_q  <= walk_q + IW'(1);
						state_q <= S_PR_RD;
					end
				end
				S_ENT_RD: state_q <= S_ENT_WR;
				S_ENT_WR: begin
					if (cmd_q == CMD_CREATE) begin
						valid_q[slot_a] <= 1'b1;
					end else if (cmd_q == CMD_EXIT) begin
						valid_q[slot_a] <= 1'b0;
					end
					state_q <= S_OUT_RD;
				end
				S_OUT_RD:  state_q <= S_OUT_MUL;
				S_OUT_MUL: state_q <= S_OUT_FIN;
				S_OUT_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q    <= cmd_t'(req.cmd);
			slot_q   <= req.slot;
			idle_q   <= req.running_idle;
			parent_q <= req.parent_slot;
			nice_q   <= nice_clamp;
			ipri_q   <= req.initial_priority;
			ready_q  <= req.ready_count;
		end
		if (state_q == S_LA_MUL) begin
			prod_q   <= PROD_W'(C5960) * PROD_W'(load_avg_q);
			la_add_q <= la_add_tab[RT_AW'(rdy_tot)];
		end
		if (state_q == S_DIV2 && div_done) begin
			coef_q <= div_quo[COEF_W-1:0];
		end
		if (state_q == S_RC_MUL) begin
			rc_s2 <= $signed({1'b0, coef_q}) * rd.recent;
		end
		if (state_q == S_OUT_MUL) begin
			rx_s2   <= rd.recent * X100_S;
			lx_s2   <= LX_W'(load_avg_q) * LX_W'(X100);
			live_s2 <= live_slot;
			pri_s2  <= rd.prio;
			nice_s2 <= rd.nice;
		end
		if (out_load) begin
			out_yield_q  <= yield_q;
			out_status_q <= status_q;
			out_pri_q    <= live_s2 ? pri_s2 : '0;
			out_nice_q   <= live_s2 ? nice_s2 : '0;
			out_rec_q    <= !live_s2 ? '0 : rx_neg ? -$signed({1'b0, rx_cl})
				: $signed({1'b0, rx_cl});
			out_la_q     <= (lx_rnd > LX_W'(LA_X_MAX)) ? 11'(LA_X_MAX) : lx_rnd[10:0];
		end
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.yield_request   = out_yield_q;
	assign rsp.priority_out    = out_pri_q;
	assign rsp.nice_out        = out_nice_q;
	assign rsp.recent_cpu_x100 = out_rec_q;
	assign rsp.load_avg_x100   = out_la_q;
	assign rsp.status          = out_status_q;

	a_no_take_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !req.ready)
		else $error("request taken while divider busy");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("table write outside a command");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV2))
		else $error("divider result arrived with no consumer");

	a_load_avg_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(load_avg_q) |-> $past(state_q == S_LA_SUM))
		else $error("load average changed outside its update step");

endmodule
